// ----- sv/opb_pkg.sv -----
// Shared types and constants for the opaque pixel bounding box block.
package opb_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int POS_W      = 12;
    localparam int SPAN_W     = 13;
    localparam int ALPHA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  top;
        logic [SPAN_W-1:0] width;
        logic [SPAN_W-1:0] height;
        logic              found;
    } t_box;

endpackage

// ----- sv/opb_cfg.sv -----
// Frame size registers, stored as clamped last column and last row indexes.
module opb_cfg
    import opb_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    parameter int CW      = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [CW-1:0]         o_last_col,
    output logic [CW-1:0]         o_last_row
);

    // clamp a size to 1..MAX_DIM and return size - 1
    function automatic logic [CW-1:0] last_index(input logic [CFG_DATA_W-1:0] value);
        logic [31:0] v;
        v = 32'(value);
        if (v == 32'd0) begin
            v = 32'd1;
        end
        if (v > 32'(MAX_DIM)) begin
            v = 32'(MAX_DIM);
        end
        return CW'(v - 32'd1);
    endfunction

    localparam logic [CW-1:0] RESET_LAST_COL = last_index(RESET_FRAME_WIDTH);
    localparam logic [CW-1:0] RESET_LAST_ROW = last_index(RESET_FRAME_HEIGHT);

    logic [CW-1:0] r_last_col;
    logic [CW-1:0] r_last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= RESET_LAST_COL;
            r_last_row <= RESET_LAST_ROW;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_last_col <= last_index(i_cfg_data);
                CFG_FRAME_HEIGHT: r_last_row <= last_index(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_last_col = r_last_col;
    assign o_last_row = r_last_row;

endmodule

// ----- sv/opb_track.sv -----
// Input register plus the raster counters and running box extents.
module opb_track
    import opb_pkg::*;
#(
    parameter int MAX_DIM = 4096,
    parameter int CW      = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic [CW-1:0]      i_last_col,
    input  logic [CW-1:0]      i_last_row,
    input  logic               i_out_free,
    output logic               o_res_valid,
    output t_box               o_res
);

    logic               r_in_valid;
    logic [ALPHA_W-1:0] r_alpha;

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_min_col, n_min_col;
    logic [CW-1:0] r_max_col, n_max_col;
    logic [CW-1:0] r_min_row, n_min_row;
    logic [CW-1:0] r_max_row, n_max_row;
    logic          r_row_has, n_row_has;
    logic          r_any, n_any;

    logic adv;
    logic opaque;
    logic seen;
    logic row_end;
    logic frame_end;
    logic [CW:0] span_col;
    logic [CW:0] span_row;

    // the held item moves on whenever the result register can take a result
    assign adv        = r_in_valid && i_out_free;
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_alpha <= i_alpha;
        end
    end

    assign opaque    = (r_alpha != '0);
    assign seen      = r_row_has || r_any;
    assign row_end   = (r_col >= i_last_col);
    assign frame_end = row_end && (r_row >= i_last_row);

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_row_has = r_row_has;
        n_any     = r_any;

        if (opaque) begin
            if (!seen || r_col < r_min_col) begin
                n_min_col = r_col;
            end
            if (!seen || r_col > r_max_col) begin
                n_max_col = r_col;
            end
            n_row_has = 1'b1;
        end

        if (!row_end) begin
            n_col = r_col + 1'b1;
        end else begin
            if (n_row_has) begin
                if (!r_any || r_row < r_min_row) begin
                    n_min_row = r_row;
                end
                if (!r_any || r_row > r_max_row) begin
                    n_max_row = r_row;
                end
                n_any = 1'b1;
            end
            n_row_has = 1'b0;
            n_col     = '0;
            if (!frame_end) begin
                n_row = r_row + 1'b1;
            end
        end
    end

    assign span_col = {1'b0, n_max_col} - {1'b0, n_min_col} + 1'b1;
    assign span_row = {1'b0, n_max_row} - {1'b0, n_min_row} + 1'b1;

    always_comb begin
        o_res_valid = adv && frame_end;
        o_res.found = n_any;
        if (n_any) begin
            o_res.left   = POS_W'(n_min_col);
            o_res.top    = POS_W'(n_min_row);
            o_res.width  = SPAN_W'(span_col);
            o_res.height = SPAN_W'(span_row);
        end else begin
            o_res.left   = '0;
            o_res.top    = '0;
            o_res.width  = '0;
            o_res.height = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_min_col <= '0;
            r_max_col <= '0;
            r_min_row <= '0;
            r_max_row <= '0;
            r_row_has <= 1'b0;
            r_any     <= 1'b0;
        end else if (adv) begin
            if (frame_end) begin
                // new frame: minima are reloaded by the first opaque pixel
                r_col     <= '0;
                r_row     <= '0;
                r_min_col <= '0;
                r_max_col <= '0;
                r_min_row <= '0;
                r_max_row <= '0;
                r_row_has <= 1'b0;
                r_any     <= 1'b0;
            end else begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_min_col <= n_min_col;
                r_max_col <= n_max_col;
                r_min_row <= n_min_row;
                r_max_row <= n_max_row;
                r_row_has <= n_row_has;
                r_any     <= n_any;
            end
        end
    end

endmodule

// ----- sv/opb_out.sv -----
// Result register holding one box until it is taken.
module opb_out
    import opb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  t_box              i_res,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [POS_W-1:0]  o_box_left,
    output logic [POS_W-1:0]  o_box_top,
    output logic [SPAN_W-1:0] o_box_width,
    output logic [SPAN_W-1:0] o_box_height,
    output logic              o_found
);

    logic r_valid;
    t_box r_box;

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_box <= i_res;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_box_left   = r_box.left;
    assign o_box_top    = r_box.top;
    assign o_box_width  = r_box.width;
    assign o_box_height = r_box.height;
    assign o_found      = r_box.found;

endmodule

// ----- sv/opaque_pixel_bounding_box_top.sv -----
// Top level of the opaque pixel bounding box block.
//
//   channel   direction  handshake                 payload
//   pixel     in         i_in_valid / o_in_ready    i_alpha
//   box       out        o_out_valid / i_out_ready  o_box_left/top/width/height, o_found
//   config    in         i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// One pixel item per clock while the result register is free. Pixels are held in
// the input register; the result register takes a frame's box as its last pixel leaves.
// Synchronous active-low reset restores 640x480 and clears frame state.
// A stalled box holds the pipeline; at most one pixel and one box are in flight.
module opaque_pixel_bounding_box_top
    import opb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ALPHA_W-1:0]    i_alpha,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [POS_W-1:0]      o_box_left,
    output logic [POS_W-1:0]      o_box_top,
    output logic [SPAN_W-1:0]     o_box_width,
    output logic [SPAN_W-1:0]     o_box_height,
    output logic                  o_found,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

    logic [CW-1:0] last_col;
    logic [CW-1:0] last_row;
    logic          out_free;
    logic          res_valid;
    t_box          res;

    opb_cfg #(.MAX_DIM(MAX_DIM), .CW(CW)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_last_col  (last_col),
        .o_last_row  (last_row)
    );

    opb_track #(.MAX_DIM(MAX_DIM), .CW(CW)) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_alpha     (i_alpha),
        .i_last_col  (last_col),
        .i_last_row  (last_row),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    opb_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_free       (out_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height),
        .o_found      (o_found)
    );

endmodule
